/* src/kwsm_pkg.sv */
// kwsm_pkg: shared types, constants and the control store of the keyword matcher
package kwsm_pkg;

    localparam int MAX_WORDS    = 64;
    localparam int MAX_WORD_LEN = 16;
    localparam int SLOT_W       = $clog2(MAX_WORDS);
    localparam int POS_W        = $clog2(MAX_WORD_LEN);
    localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
    localparam int CNT_W        = 7;
    localparam int CFG_W        = 7;
    localparam int ACT_W        = 2;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 8;

    localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BYTE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EOM  = 2'd2;

    localparam logic REG_WORDS_IN_USE  = 1'b0;
    localparam logic REG_HIT_THRESHOLD = 1'b1;

    typedef logic [MAX_WORD_LEN-1:0][7:0] kw_row_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COUNT,
        ST_EMIT
    } step_t;

    typedef enum logic [1:0] {
        J_DISPATCH,
        J_LOOP,
        J_WAIT_OUT
    } jmp_t;

    typedef struct packed {
        logic  accept;
        logic  scan;
        logic  count;
        logic  emit;
        jmp_t  jmp;
        step_t exit_to;
    } ctl_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  pos;
        logic              fin;
        logic [7:0]        data;
    } wr_req_t;

    function automatic ctl_t ucode(step_t step);
        ctl_t cw;
        cw = '0;
        unique case (step)
            ST_IDLE: begin
                cw.accept  = 1'b1;
                cw.jmp     = J_DISPATCH;
                cw.exit_to = ST_IDLE;
            end
            ST_SCAN: begin
                cw.scan    = 1'b1;
                cw.jmp     = J_LOOP;
                cw.exit_to = ST_IDLE;
            end
            ST_COUNT: begin
                cw.count   = 1'b1;
                cw.jmp     = J_LOOP;
                cw.exit_to = ST_EMIT;
            end
            ST_EMIT: begin
                cw.emit    = 1'b1;
                cw.jmp     = J_WAIT_OUT;
                cw.exit_to = ST_IDLE;
            end
            default: cw = '0;
        endcase
        return cw;
    endfunction

    function automatic logic [7:0] fold_case(logic [7:0] b);
        if (b >= 8'h41 && b <= 8'h5A) begin
            return b + 8'h20;
        end
        return b;
    endfunction

endpackage

/* src/keyword_spam_matcher.sv */
// keyword_spam_matcher: top level, control sequencer and matching datapath
// Case-insensitive keyword matcher. A message byte walks the active slots
// (words_in_use capped at 64): the sequencer walks the slots one per cycle
// through the single read port of the keyword row memory and compares all
// characters of a slot, up to its length, at once. An end-of-message word
// walks the slots as well and may wait for the previous result to be taken.
// No word is accepted during a walk. No clearing pass is needed after reset.
module keyword_spam_matcher (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // word_slot[5:0], char_pos[9:6], data_byte[17:10], zero fill
    input  logic [kwsm_pkg::IN_TDATA_W-1:0]  s_tdata,
    // action[1:0]
    input  logic [kwsm_pkg::ACT_W-1:0]       s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit_count[6:0], is_spam[7]
    output logic [kwsm_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [kwsm_pkg::CFG_W-1:0]       cfg_wdata
);
    import kwsm_pkg::*;

    step_t step_reg, step_next;
    ctl_t  cw;

    logic [CFG_W-1:0] words_reg;
    logic [CFG_W-1:0] thr_reg;
    logic [CNT_W-1:0] n_words;

    logic [CNT_W-1:0] cnt_reg;
    logic             walk_en;
    logic             pipe_valid_reg;
    logic             pipe_count_reg;
    logic [SLOT_W-1:0] pipe_slot_reg;

    logic [MAX_WORD_LEN-1:0][7:0] recent_reg;
    logic [LEN_W-1:0] seen_reg;
    logic [MAX_WORDS-1:0] hit_reg;
    logic [CNT_W-1:0] count_reg;

    logic             m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    logic             in_go;
    logic             out_busy;
    logic             emit_go;
    logic [7:0]       in_byte;
    wr_req_t          wr_req;
    kw_row_t          rd_row;
    logic [LEN_W-1:0] rd_len;
    logic             slot_match;

    assign cw       = ucode(step_reg);
    assign s_tready = cw.accept;
    assign in_go    = s_tvalid && cw.accept;
    assign in_byte  = fold_case(s_tdata[17:10]);
    assign out_busy = m_valid_reg && !m_tready;
    assign emit_go  = cw.emit && !out_busy;
    assign n_words  = (words_reg > CNT_W'(MAX_WORDS)) ? CNT_W'(MAX_WORDS) : words_reg;
    assign walk_en  = (cw.scan || cw.count) && (cnt_reg < n_words);

    always_comb begin
        step_next = step_reg;
        unique case (cw.jmp)
            J_DISPATCH: begin
                if (s_tvalid) begin
                    unique case (s_tuser)
                        ACT_BYTE: step_next = ST_SCAN;
                        ACT_EOM:  step_next = ST_COUNT;
                        default:  step_next = ST_IDLE;
                    endcase
                end
            end
            J_LOOP: begin
                if (!(cnt_reg < n_words)) begin
                    step_next = cw.exit_to;
                end
            end
            J_WAIT_OUT: begin
                if (!out_busy) begin
                    step_next = cw.exit_to;
                end
            end
            default: step_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_reg <= '0;
            thr_reg   <= CFG_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WORDS_IN_USE:  words_reg <= cfg_wdata;
                REG_HIT_THRESHOLD: thr_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        wr_req      = '0;
        wr_req.en   = in_go && (s_tuser == ACT_LOAD);
        wr_req.slot = s_tdata[5:0];
        wr_req.pos  = s_tdata[9:6];
        wr_req.fin  = s_tlast;
        wr_req.data = in_byte;
    end

    kwsm_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_req  (wr_req),
        .rd_addr (cnt_reg[SLOT_W-1:0]),
        .rd_row  (rd_row),
        .rd_len  (rd_len)
    );

    // compare the fetched slot against the newest bytes
    always_comb begin
        logic [LEN_W-1:0] ridx;
        slot_match = (rd_len <= seen_reg);
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
            ridx = rd_len - LEN_W'(1) - LEN_W'(i);
            if (LEN_W'(i) < rd_len) begin
                if (rd_row[i] != recent_reg[ridx[POS_W-1:0]]) begin
                    slot_match = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            pipe_count_reg <= 1'b0;
            recent_reg     <= '0;
            seen_reg       <= '0;
            hit_reg        <= '0;
            count_reg      <= '0;
        end else begin
            pipe_valid_reg <= walk_en;
            pipe_count_reg <= cw.count;
            if (walk_en) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (in_go && (s_tuser == ACT_BYTE)) begin
                recent_reg <= {recent_reg[MAX_WORD_LEN-2:0], in_byte};
                if (seen_reg < LEN_W'(MAX_WORD_LEN)) begin
                    seen_reg <= seen_reg + LEN_W'(1);
                end
                cnt_reg <= '0;
            end
            if (in_go && (s_tuser == ACT_EOM)) begin
                cnt_reg   <= '0;
                count_reg <= '0;
            end
            if (pipe_valid_reg && !pipe_count_reg && slot_match) begin
                hit_reg[pipe_slot_reg] <= 1'b1;
            end
            if (pipe_valid_reg && pipe_count_reg
                    && (hit_reg[pipe_slot_reg] || rd_len == '0)
                    && count_reg != '1) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (emit_go) begin
                hit_reg    <= '0;
                recent_reg <= '0;
                seen_reg   <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pipe_slot_reg <= cnt_reg[SLOT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_go) begin
            m_data_reg <= {(count_reg >= thr_reg), count_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_ready_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pipe_valid_reg)
        else $error("word accepted while slot walk still in flight");

    a_pipe_from_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_valid_reg |-> ($past(step_reg) == ST_SCAN || $past(step_reg) == ST_COUNT))
        else $error("slot fetch outside a walk step");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_WORDS))
        else $error("hit count above slot count");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(step_reg) == ST_EMIT)
        else $error("result raised outside emit step");

endmodule

/* src/kwsm_store.sv */
// kwsm_store: keyword character rows and keyword lengths with registered reads
module kwsm_store (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  kwsm_pkg::wr_req_t           wr_req,
    input  logic [kwsm_pkg::SLOT_W-1:0] rd_addr,
    output kwsm_pkg::kw_row_t           rd_row,
    output logic [kwsm_pkg::LEN_W-1:0]  rd_len
);
    import kwsm_pkg::*;

    kw_row_t          row_mem [MAX_WORDS];
    logic [LEN_W-1:0] len_mem [MAX_WORDS];
    logic [MAX_WORDS-1:0] len_valid_reg;
    kw_row_t          rd_row_reg;
    logic [LEN_W-1:0] rd_len_reg;

    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            row_mem[wr_req.slot][wr_req.pos] <= wr_req.data;
        end
        rd_row_reg <= row_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_req.en && wr_req.fin) begin
            len_mem[wr_req.slot] <= LEN_W'(wr_req.pos) + LEN_W'(1);
        end
        rd_len_reg <= len_valid_reg[rd_addr] ? len_mem[rd_addr] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_valid_reg <= '0;
        end else if (wr_req.en && wr_req.fin) begin
            len_valid_reg[wr_req.slot] <= 1'b1;
        end
    end

    assign rd_row = rd_row_reg;
    assign rd_len = rd_len_reg;

endmodule

/* test/tb_top.sv */
// tb_top: self-checking stream testbench for keyword_spam_matcher
module tb_top;
    import kwsm_pkg::*;

    localparam int ITEMS_TARGET = 850;
    localparam int QUIET_TAIL   = 120;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 100;
    localparam int LONG_HOLD    = 400;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] hit_count;
        logic             is_spam;
    } verdict_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [ACT_W-1:0]       s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en;
    logic                   cfg_index;
    logic [CFG_W-1:0]       cfg_wdata;

    // matcher state as seen from outside
    logic [7:0]              kw_chars   [MAX_WORDS][MAX_WORD_LEN];
    int                      kw_len     [MAX_WORDS];
    logic [MAX_WORD_LEN-1:0] kw_written [MAX_WORDS];
    logic                    hit_flag   [MAX_WORDS];
    logic [7:0]              recent     [MAX_WORD_LEN];
    int                      seen;
    logic [CFG_W-1:0]        words_reg;
    logic [CFG_W-1:0]        thresh_reg;

    // newest expected result at the front, oldest at the back
    verdict_t verdicts[$];
    int       errors = 0;
    int       items_sent = 0;
    longint   cycles = 0;
    bit       idle_on = 0;
    bit       long_hold_req = 0;
    int       hold_left = 0;

    keyword_spam_matcher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side ready, random stalls and one long hold-off
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else if (long_hold_req) begin
            long_hold_req = 0;
            m_tready = 1'b0;
            hold_left = LONG_HOLD - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_tready = 1'b0;
            hold_left = $urandom_range(0, 14);
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdicts.size() == 0) begin
                $error("result word with none expected: %h", m_tdata);
                errors++;
            end else begin
                want = verdicts.pop_back();
                if (m_tdata[6:0] !== want.hit_count) begin
                    $error("hit_count expected %0d got %0d", want.hit_count, m_tdata[6:0]);
                    errors++;
                end
                if (m_tdata[7] !== want.is_spam) begin
                    $error("is_spam expected %0d got %0d", want.is_spam, m_tdata[7]);
                    errors++;
                end
            end
        end
    end

    function automatic logic [7:0] lower(logic [7:0] b);
        return (b inside {[8'h41:8'h5A]}) ? (b | 8'h20) : b;
    endfunction

    function automatic int active_slots();
        return (words_reg > MAX_WORDS) ? MAX_WORDS : int'(words_reg);
    endfunction

    function automatic void clear_message();
        foreach (hit_flag[s]) hit_flag[s] = 1'b0;
        foreach (recent[i]) recent[i] = 8'h00;
        seen = 0;
    endfunction

    function automatic bit slot_hit(int s);
        if (kw_len[s] > seen) return 0;
        for (int i = 0; i < kw_len[s]; i++) begin
            if (kw_chars[s][i] != recent[kw_len[s] - 1 - i]) return 0;
        end
        return 1;
    endfunction

    function automatic void predict(logic [ACT_W-1:0] act, logic [SLOT_W-1:0] slot,
                                    logic [POS_W-1:0] pos, logic fin, logic [7:0] raw);
        logic [7:0] b;
        int         count;
        verdict_t   v;
        b = lower(raw);
        case (act)
            ACT_LOAD: begin
                kw_chars[slot][pos] = b;
                kw_written[slot][pos] = 1'b1;
                if (fin) kw_len[slot] = pos + 1;
            end
            ACT_BYTE: begin
                for (int i = MAX_WORD_LEN - 1; i > 0; i--) recent[i] = recent[i-1];
                recent[0] = b;
                if (seen < MAX_WORD_LEN) seen++;
                for (int s = 0; s < active_slots(); s++) begin
                    if (slot_hit(s)) hit_flag[s] = 1'b1;
                end
            end
            ACT_EOM: begin
                count = 0;
                for (int s = 0; s < active_slots(); s++) begin
                    if (hit_flag[s] || kw_len[s] == 0) count++;
                end
                v.hit_count = count[CNT_W-1:0];
                v.is_spam   = (count >= int'(thresh_reg));
                verdicts.push_front(v);
                clear_message();
            end
            default: ;
        endcase
    endfunction

    task automatic send(input logic [ACT_W-1:0] act, input logic [SLOT_W-1:0] slot,
                        input logic [POS_W-1:0] pos, input logic fin, input logic [7:0] data);
        int gap;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tlast  = fin;
        s_tdata  = {6'b0, data, pos, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict(act, slot, pos, fin, data);
        if (act != ACT_UNUSED) items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] data);
        send(ACT_BYTE, SLOT_W'($urandom), POS_W'($urandom), 1'($urandom), data);
    endtask

    task automatic send_eom();
        send(ACT_EOM, SLOT_W'($urandom), POS_W'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == REG_WORDS_IN_USE) words_reg = val;
        else thresh_reg = val;
    endtask

    task automatic load_word(input int slot, input logic [7:0] chars[$]);
        foreach (chars[i]) begin
            send(ACT_LOAD, SLOT_W'(slot), POS_W'(i), i == chars.size() - 1, chars[i]);
        end
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = 8'h61 + 8'($urandom_range(0, 5));
        if ($urandom_range(0, 1)) c = c - 8'h20;
        return c;
    endfunction

    task automatic load_random_word(input int slot);
        logic [7:0] chars[$];
        int         len;
        len = ($urandom_range(0, 19) == 0) ? MAX_WORD_LEN : $urandom_range(1, 5);
        repeat (len) begin
            chars.push_front(($urandom_range(0, 9) == 0) ? 8'($urandom) : rand_letter());
        end
        load_word(slot, chars);
    endtask

    // overwrite one keyword char; the length mark only where the prefix is loaded
    task automatic stray_load();
        int                      slot;
        int                      pos;
        int                      low_mask;
        logic                    fin;
        logic [MAX_WORD_LEN-1:0] after;
        slot = $urandom_range(0, MAX_WORDS - 1);
        pos = $urandom_range(0, MAX_WORD_LEN - 1);
        after = kw_written[slot] | (MAX_WORD_LEN'(1) << pos);
        low_mask = (1 << (pos + 1)) - 1;
        fin = $urandom_range(0, 1) && ((int'(after) & low_mask) == low_mask);
        send(ACT_LOAD, SLOT_W'(slot), POS_W'(pos), fin, 8'($urandom));
    endtask

    // echo one in-use keyword with random letter case
    task automatic send_keyword_copy();
        int         s;
        logic [7:0] c;
        s = -1;
        repeat (8) begin
            if (s < 0 && active_slots() > 0) begin
                s = $urandom_range(0, active_slots() - 1);
                if (kw_len[s] == 0) s = -1;
            end
        end
        if (s < 0) begin
            send_byte(rand_letter());
        end else begin
            for (int i = 0; i < kw_len[s]; i++) begin
                c = kw_chars[s][i];
                if (c inside {[8'h61:8'h7A]} && $urandom_range(0, 1)) c = c - 8'h20;
                send_byte(c);
            end
        end
    endtask

    task automatic send_message_piece();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            send_keyword_copy();
        end else if (r < 85) begin
            send_byte(rand_letter());
        end else if (r < 92) begin
            send_byte(8'($urandom));
        end else if (r < 96) begin
            stray_load();
        end else begin
            send(ACT_UNUSED, SLOT_W'($urandom), POS_W'($urandom), 1'($urandom),
                 8'($urandom));
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_words();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 70) return CFG_W'($urandom_range(1, 8));
        if (r < 90) return CFG_W'($urandom_range(9, MAX_WORDS));
        return CFG_W'($urandom_range(MAX_WORDS + 1, 127));
    endfunction

    task automatic test_reset_state();
        send_eom();
        drain();
        write_reg(REG_WORDS_IN_USE, 64);
        write_reg(REG_HIT_THRESHOLD, 64);
        send_eom();
        drain();
        write_reg(REG_WORDS_IN_USE, 127);
        write_reg(REG_HIT_THRESHOLD, 127);
        send_eom();
        drain();
        write_reg(REG_WORDS_IN_USE, 0);
        write_reg(REG_HIT_THRESHOLD, 0);
        send_eom();
    endtask

    task automatic test_case_folding();
        drain();
        write_reg(REG_WORDS_IN_USE, 3);
        write_reg(REG_HIT_THRESHOLD, 2);
        load_word(0, '{8'h41, 8'h7A});
        load_word(1, '{8'h40, 8'h5B});
        load_word(2, '{8'h00});
        send_byte(8'h61);
        send_byte(8'h5A);
        send_byte(8'h40);
        send_byte(8'h5B);
        send_eom();
        send_byte(8'h60);
        send_byte(8'h7B);
        send_byte(8'h00);
        send_eom();
    endtask

    task automatic test_stray_items();
        send(ACT_UNUSED, '1, '1, 1'b1, 8'hFF);
        send(ACT_LOAD, SLOT_W'(MAX_WORDS - 1), POS_W'(MAX_WORD_LEN - 1), 1'b0, 8'hFF);
        send_eom();
    endtask

    task automatic test_mid_message_change();
        send_byte(8'h40);
        send_byte(8'h5B);
        drain();
        write_reg(REG_WORDS_IN_USE, 4);
        send_byte(8'h41);
        send_byte(8'h7A);
        send_eom();
    endtask

    task automatic test_backpressure();
        drain();
        long_hold_req = 1;
        send_byte(8'h61);
        repeat (4) send_eom();
        drain();
    endtask

    task automatic test_random();
        int n;
        int len;
        while (items_sent < ITEMS_TARGET) begin
            drain();
            idle_on = (items_sent < ITEMS_TARGET - QUIET_TAIL) && ($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 1)) begin
                write_reg(REG_WORDS_IN_USE, pick_words());
                write_reg(REG_HIT_THRESHOLD, ($urandom_range(0, 4) == 0) ?
                          CFG_W'($urandom) : CFG_W'($urandom_range(0, 4)));
            end else begin
                write_reg(REG_HIT_THRESHOLD, ($urandom_range(0, 4) == 0) ?
                          CFG_W'($urandom) : CFG_W'($urandom_range(0, 4)));
                write_reg(REG_WORDS_IN_USE, pick_words());
            end
            n = active_slots();
            if (n > 0) begin
                repeat ($urandom_range(0, (n < 4) ? n : 4)) begin
                    load_random_word($urandom_range(0, n - 1));
                end
            end
            repeat ($urandom_range(1, 3)) begin
                len = $urandom_range(0, 20);
                for (int k = 0; k < len; k++) begin
                    if (k == len / 2 && $urandom_range(0, 9) == 0) begin
                        drain();
                        write_reg(REG_WORDS_IN_USE, pick_words());
                    end
                    send_message_piece();
                end
                send_eom();
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        foreach (kw_len[s]) begin
            kw_len[s] = 0;
            kw_written[s] = '0;
            for (int i = 0; i < MAX_WORD_LEN; i++) kw_chars[s][i] = 8'h00;
        end
        clear_message();
        words_reg  = 0;
        thresh_reg = 1;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_case_folding();
        test_stray_items();
        test_mid_message_change();
        test_backpressure();
        test_random();

        idle_on = 0;
        drain();
        if (errors == 0 && verdicts.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
